// ----- rtl/core/pcavg_pkg.sv -----
package pcavg_pkg;

   localparam int HALF_LEN   = 16;
   localparam int ADC_BITS   = 12;
   localparam int WIN_LEN    = 2 * HALF_LEN;
   // The window average divides by a shift, so HALF_LEN is kept a power of two.
   localparam int HALF_SHIFT = $clog2(HALF_LEN);
   localparam int WIN_SHIFT  = $clog2(WIN_LEN);
   localparam int RING_W     = WIN_SHIFT;
   localparam int PSUM_W     = ADC_BITS + HALF_SHIFT;
   localparam int WSUM_W     = PSUM_W + 1;
   localparam int FRAC_Q     = 5;
   localparam int AVQ_W      = WSUM_W + FRAC_Q - WIN_SHIFT;
   localparam int OFS_W      = 17;
   localparam int GAIN_W     = 32;
   localparam int DIFF_W     = ((AVQ_W > OFS_W) ? AVQ_W : OFS_W) + 1;
   localparam int PROD_W     = DIFF_W + GAIN_W;
   localparam int RND_SHIFT  = 13;
   localparam int CUR_W      = 32;
   localparam int RAW_W      = 12;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 32;

   localparam logic [OFS_W-1:0] OFFSET_MAX = OFS_W'(131040);

   localparam logic [2:0] ST_OK          = 3'd0;
   localparam logic [2:0] ST_HW          = 3'd1;
   localparam logic [2:0] ST_NOT_STARTED = 3'd2;
   localparam logic [2:0] ST_NOT_READY   = 3'd3;
   localparam logic [2:0] ST_NOT_CAL     = 3'd4;

   localparam logic [1:0] HALF0_BIT   = 2'b01;
   localparam logic [1:0] HALF1_BIT   = 2'b10;
   localparam logic [1:0] BOTH_HALVES = 2'b11;

   typedef enum logic [1:0] {
      CMD_SAMPLE = 2'd0,
      CMD_START  = 2'd1,
      CMD_STOP   = 2'd2,
      CMD_ERROR  = 2'd3
   } cmd_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_ZERO_OFFSET = 2'd0,
      REG_COUNT_GAIN  = 2'd1,
      REG_CALIBRATED  = 2'd2
   } reg_idx_type;

   typedef struct packed {
      logic [1:0]  cmd;
      logic [11:0] sample;
   } req_type;

   typedef struct packed {
      logic [1:0]              cmd_status;
      logic [1:0]              latest_status;
      logic [11:0]             latest_raw;
      logic [1:0]              average_status;
      logic [11:0]             average_raw;
      logic [2:0]              current_status;
      logic signed [CUR_W-1:0] current_value;
   } rsp_type;

   typedef struct packed {
      logic [OFS_W-1:0]         zero_offset;
      logic signed [GAIN_W-1:0] count_gain;
      logic                     calibrated;
   } cfg_type;

   // State after one item, as the later stages need it.
   typedef struct packed {
      logic [1:0]          cmd_status;
      logic                hw_fault;
      logic                running;
      logic [1:0]          half_valid;
      logic [WSUM_W-1:0]   window_sum;
      logic [ADC_BITS-1:0] last_sample;
   } snap_type;

   typedef struct packed {
      logic [1:0]               cmd_status;
      logic [1:0]               latest_status;
      logic [RAW_W-1:0]         latest_raw;
      logic [1:0]               average_status;
      logic [RAW_W-1:0]         average_raw;
      logic [2:0]               current_status;
      logic signed [DIFF_W-1:0] diff;
   } calc_type;

   typedef struct packed {
      logic [1:0]               cmd_status;
      logic [1:0]               latest_status;
      logic [RAW_W-1:0]         latest_raw;
      logic [1:0]               average_status;
      logic [RAW_W-1:0]         average_raw;
      logic [2:0]               current_status;
      logic signed [PROD_W-1:0] product;
   } prod_type;

endpackage

// ----- rtl/core/ping_pong_current_average.sv -----
// Each accepted item passes in turn through the state, status, product and output registers.
// Throughput: one item per cycle while the output is not stalled; the stages are state update, status and offset,
// the 18 x 32 gain multiplier, and rounding with saturation into the output register.
// Reset is synchronous: it clears the run state, the sums, the configuration registers
// and all stage valid flags.
module ping_pong_current_average (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  pcavg_pkg::req_type                    req_data,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output pcavg_pkg::rsp_type                    rsp_data,
   input  logic                                  csr_we,
   input  logic [pcavg_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [pcavg_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   logic v1_ff, v2_ff, v3_ff, vo_ff;
   logic out_free, s3_free, s2_free, s1_free, req_fire;

   pcavg_pkg::cfg_type  cfg_ff;
   pcavg_pkg::snap_type snap;
   pcavg_pkg::calc_type calc;
   pcavg_pkg::prod_type prod;

   // A stage takes new data when it is empty or its contents move on.
   assign out_free = !vo_ff || rsp_ready;
   assign s3_free  = !v3_ff || out_free;
   assign s2_free  = !v2_ff || s3_free;
   assign s1_free  = !v1_ff || s2_free;
   assign req_ready = s1_free;
   assign req_fire  = req_valid && s1_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         vo_ff <= 1'b0;
      end else begin
         if (s1_free) begin
            v1_ff <= req_fire;
         end
         if (s2_free) begin
            v2_ff <= v1_ff;
         end
         if (s3_free) begin
            v3_ff <= v2_ff;
         end
         if (out_free) begin
            vo_ff <= v3_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.zero_offset <= '0;
         cfg_ff.count_gain  <= '0;
         cfg_ff.calibrated  <= 1'b0;
      end else if (csr_we) begin
         case (pcavg_pkg::reg_idx_type'(csr_index))
            pcavg_pkg::REG_ZERO_OFFSET: begin
               cfg_ff.zero_offset <= csr_wdata[pcavg_pkg::OFS_W-1:0];
            end
            pcavg_pkg::REG_COUNT_GAIN: begin
               cfg_ff.count_gain <= signed'(csr_wdata[pcavg_pkg::GAIN_W-1:0]);
            end
            pcavg_pkg::REG_CALIBRATED: begin
               cfg_ff.calibrated <= csr_wdata[0];
            end
            default: begin
               cfg_ff <= cfg_ff;
            end
         endcase
      end
   end

   pcavg_state u_state (
      .clock (clock),
      .reset (reset),
      .fire  (req_fire),
      .req   (req_data),
      .load  (s1_free),
      .snap  (snap)
   );

   pcavg_status u_status (
      .clock (clock),
      .load  (s2_free),
      .snap  (snap),
      .cfg   (cfg_ff),
      .calc  (calc)
   );

   pcavg_mult u_mult (
      .clock (clock),
      .load  (s3_free),
      .calc  (calc),
      .cfg   (cfg_ff),
      .prod  (prod)
   );

   pcavg_out u_out (
      .clock (clock),
      .load  (out_free),
      .prod  (prod),
      .rsp   (rsp_data)
   );

   assign rsp_valid = vo_ff;

endmodule

// ----- rtl/core/pcavg_state.sv -----
module pcavg_state (
   input  logic                clock,
   input  logic                reset,
   input  logic                fire,
   input  pcavg_pkg::req_type  req,
   input  logic                load,
   output pcavg_pkg::snap_type snap
);

   localparam int RING_W   = pcavg_pkg::RING_W;
   localparam int PSUM_W   = pcavg_pkg::PSUM_W;
   localparam int WSUM_W   = pcavg_pkg::WSUM_W;
   localparam int ADC_BITS = pcavg_pkg::ADC_BITS;
   localparam int HSH      = pcavg_pkg::HALF_SHIFT;

   logic                running_ff, running_in;
   logic                hw_fault_ff, hw_fault_in;
   logic [1:0]          half_valid_ff, half_valid_in;
   logic [RING_W-1:0]   ring_ff, ring_in;
   logic [PSUM_W-1:0]   psum_ff, psum_in;
   logic [PSUM_W-1:0]   half_total_ff [2];
   logic [PSUM_W-1:0]   half_total_in [2];
   logic [WSUM_W-1:0]   window_ff, window_in;
   logic [ADC_BITS-1:0] last_ff, last_in;
   logic [1:0]          cmd_status;
   pcavg_pkg::snap_type snap_ff;

   logic [ADC_BITS-1:0] smp;
   logic [PSUM_W-1:0]   psum_add;
   logic                half;
   logic [1:0]          hv_new;

   assign smp      = req.sample[ADC_BITS-1:0];
   assign psum_add = psum_ff + PSUM_W'(smp);
   assign half     = ring_ff[RING_W-1];
   assign hv_new   = half_valid_ff | (half ? pcavg_pkg::HALF1_BIT : pcavg_pkg::HALF0_BIT);

   always_comb begin
      running_in       = running_ff;
      hw_fault_in      = hw_fault_ff;
      half_valid_in    = half_valid_ff;
      ring_in          = ring_ff;
      psum_in          = psum_ff;
      half_total_in[0] = half_total_ff[0];
      half_total_in[1] = half_total_ff[1];
      window_in        = window_ff;
      last_in          = last_ff;
      cmd_status       = pcavg_pkg::ST_OK[1:0];
      if (fire) begin
         case (pcavg_pkg::cmd_type'(req.cmd))
            pcavg_pkg::CMD_SAMPLE: begin
               if (running_ff) begin
                  ring_in = ring_ff + RING_W'(1);
                  if (ring_ff[HSH-1:0] == '1) begin
                     half_total_in[half] = psum_add;
                     last_in             = smp;
                     half_valid_in       = hv_new;
                     psum_in             = '0;
                     if (hv_new == pcavg_pkg::BOTH_HALVES) begin
                        window_in = {1'b0, (half ? half_total_ff[0] : psum_add)}
                                  + {1'b0, (half ? psum_add : half_total_ff[1])};
                     end
                  end else begin
                     psum_in = psum_add;
                  end
               end
            end
            pcavg_pkg::CMD_START: begin
               if (running_ff) begin
                  cmd_status = hw_fault_ff ? pcavg_pkg::ST_HW[1:0] : pcavg_pkg::ST_OK[1:0];
               end else begin
                  running_in       = 1'b1;
                  hw_fault_in      = 1'b0;
                  half_valid_in    = '0;
                  ring_in          = '0;
                  psum_in          = '0;
                  half_total_in[0] = '0;
                  half_total_in[1] = '0;
                  window_in        = '0;
                  last_in          = '0;
               end
            end
            pcavg_pkg::CMD_STOP: begin
               if (!running_ff) begin
                  cmd_status = pcavg_pkg::ST_NOT_STARTED[1:0];
               end else begin
                  running_in    = 1'b0;
                  half_valid_in = '0;
               end
            end
            pcavg_pkg::CMD_ERROR: begin
               hw_fault_in   = 1'b1;
               half_valid_in = '0;
            end
            default: begin
               hw_fault_in = hw_fault_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         running_ff       <= 1'b0;
         hw_fault_ff      <= 1'b0;
         half_valid_ff    <= '0;
         ring_ff          <= '0;
         psum_ff          <= '0;
         half_total_ff[0] <= '0;
         half_total_ff[1] <= '0;
         window_ff        <= '0;
         last_ff          <= '0;
      end else begin
         running_ff       <= running_in;
         hw_fault_ff      <= hw_fault_in;
         half_valid_ff    <= half_valid_in;
         ring_ff          <= ring_in;
         psum_ff          <= psum_in;
         half_total_ff[0] <= half_total_in[0];
         half_total_ff[1] <= half_total_in[1];
         window_ff        <= window_in;
         last_ff          <= last_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         snap_ff.cmd_status  <= cmd_status;
         snap_ff.hw_fault    <= hw_fault_in;
         snap_ff.running     <= running_in;
         snap_ff.half_valid  <= half_valid_in;
         snap_ff.window_sum  <= window_in;
         snap_ff.last_sample <= last_in;
      end
   end

   assign snap = snap_ff;

endmodule

// ----- rtl/core/pcavg_status.sv -----
module pcavg_status (
   input  logic                clock,
   input  logic                load,
   input  pcavg_pkg::snap_type snap,
   input  pcavg_pkg::cfg_type  cfg,
   output pcavg_pkg::calc_type calc
);

   localparam int WSUM_W  = pcavg_pkg::WSUM_W;
   localparam int FRAC_Q  = pcavg_pkg::FRAC_Q;
   localparam int QN_W    = WSUM_W + FRAC_Q;
   localparam int AVQ_W   = pcavg_pkg::AVQ_W;
   localparam int DIFF_W  = pcavg_pkg::DIFF_W;
   localparam int RAW_W   = pcavg_pkg::RAW_W;
   localparam int ADC_B   = pcavg_pkg::ADC_BITS;

   logic [2:0]               base, ls, as, cs;
   logic [WSUM_W:0]          avg_num;
   logic [WSUM_W:0]          avg_full;
   logic [QN_W-1:0]          q5_num;
   logic [QN_W-1:0]          q5_full;
   logic [AVQ_W-1:0]         avg_q5;
   logic signed [DIFF_W-1:0] diff;
   logic                     uncal;
   pcavg_pkg::calc_type      calc_in, calc_ff;

   always_comb begin
      if (snap.hw_fault) begin
         base = pcavg_pkg::ST_HW;
      end else if (!snap.running) begin
         base = pcavg_pkg::ST_NOT_STARTED;
      end else begin
         base = pcavg_pkg::ST_OK;
      end
      ls = base;
      if (base == pcavg_pkg::ST_OK && snap.half_valid == '0) begin
         ls = pcavg_pkg::ST_NOT_READY;
      end
      as = base;
      if (base == pcavg_pkg::ST_OK && snap.half_valid != pcavg_pkg::BOTH_HALVES) begin
         as = pcavg_pkg::ST_NOT_READY;
      end
      uncal = !cfg.calibrated || (cfg.count_gain == '0)
            || (cfg.zero_offset > pcavg_pkg::OFFSET_MAX);
      cs = (as == pcavg_pkg::ST_OK && uncal) ? pcavg_pkg::ST_NOT_CAL : as;
   end

   // Rounded window average, in counts and in Q12.5.
   assign avg_num  = {1'b0, snap.window_sum} + (WSUM_W+1)'(pcavg_pkg::HALF_LEN);
   assign avg_full = avg_num >> pcavg_pkg::WIN_SHIFT;
   assign q5_num   = {snap.window_sum, {FRAC_Q{1'b0}}} + QN_W'(pcavg_pkg::HALF_LEN);
   assign q5_full  = q5_num >> pcavg_pkg::WIN_SHIFT;
   assign avg_q5   = q5_full[AVQ_W-1:0];
   assign diff     = DIFF_W'(signed'({1'b0, avg_q5})) - DIFF_W'(signed'({1'b0, cfg.zero_offset}));

   always_comb begin
      calc_in.cmd_status     = snap.cmd_status;
      calc_in.latest_status  = ls[1:0];
      calc_in.latest_raw     = (ls == pcavg_pkg::ST_OK) ? RAW_W'(snap.last_sample) : '0;
      calc_in.average_status = as[1:0];
      calc_in.average_raw    = (as == pcavg_pkg::ST_OK) ? RAW_W'(avg_full[ADC_B-1:0]) : '0;
      calc_in.current_status = cs;
      calc_in.diff           = diff;
   end

   always_ff @(posedge clock) begin
      if (load) begin
         calc_ff <= calc_in;
      end
   end

   assign calc = calc_ff;

endmodule

// ----- rtl/core/pcavg_mult.sv -----
module pcavg_mult (
   input  logic                clock,
   input  logic                load,
   input  pcavg_pkg::calc_type calc,
   input  pcavg_pkg::cfg_type  cfg,
   output pcavg_pkg::prod_type prod
);

   logic signed [pcavg_pkg::DIFF_W-1:0] diff;
   logic signed [pcavg_pkg::GAIN_W-1:0] gain;
   logic signed [pcavg_pkg::PROD_W-1:0] product;
   pcavg_pkg::prod_type                 prod_ff;

   assign diff    = calc.diff;
   assign gain    = cfg.count_gain;
   assign product = pcavg_pkg::PROD_W'(diff * gain);

   always_ff @(posedge clock) begin
      if (load) begin
         prod_ff.cmd_status     <= calc.cmd_status;
         prod_ff.latest_status  <= calc.latest_status;
         prod_ff.latest_raw     <= calc.latest_raw;
         prod_ff.average_status <= calc.average_status;
         prod_ff.average_raw    <= calc.average_raw;
         prod_ff.current_status <= calc.current_status;
         prod_ff.product        <= product;
      end
   end

   assign prod = prod_ff;

endmodule

// ----- rtl/core/pcavg_out.sv -----
module pcavg_out (
   input  logic                clock,
   input  logic                load,
   input  pcavg_pkg::prod_type prod,
   output pcavg_pkg::rsp_type  rsp
);

   localparam int PROD_W = pcavg_pkg::PROD_W;
   localparam int RSH    = pcavg_pkg::RND_SHIFT;
   localparam int Q_W    = PROD_W + 1 - RSH;
   localparam int CUR_W  = pcavg_pkg::CUR_W;

   localparam logic signed [Q_W-1:0] CUR_MAX = {{(Q_W-CUR_W+1){1'b0}}, {(CUR_W-1){1'b1}}};
   localparam logic signed [Q_W-1:0] CUR_MIN = {{(Q_W-CUR_W+1){1'b1}}, {(CUR_W-1){1'b0}}};

   logic signed [PROD_W:0]    rnd;
   logic signed [Q_W-1:0]     q;
   logic signed [CUR_W-1:0]   sat;
   pcavg_pkg::rsp_type        rsp_ff;

   // Round half up to Q16.16: add half an LSB, then floor by arithmetic shift.
   assign rnd = (PROD_W+1)'(prod.product) + (PROD_W+1)'(1 << (RSH - 1));
   assign q   = $signed(rnd[PROD_W:RSH]);

   always_comb begin
      if (q > CUR_MAX) begin
         sat = CUR_MAX[CUR_W-1:0];
      end else if (q < CUR_MIN) begin
         sat = CUR_MIN[CUR_W-1:0];
      end else begin
         sat = q[CUR_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_ff.cmd_status     <= prod.cmd_status;
         rsp_ff.latest_status  <= prod.latest_status;
         rsp_ff.latest_raw     <= prod.latest_raw;
         rsp_ff.average_status <= prod.average_status;
         rsp_ff.average_raw    <= prod.average_raw;
         rsp_ff.current_status <= prod.current_status;
         rsp_ff.current_value  <= (prod.current_status == pcavg_pkg::ST_OK) ? sat : '0;
      end
   end

   assign rsp = rsp_ff;

endmodule

// ----- rtl/core/pcavg_checker.sv -----
module pcavg_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_ready,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input pcavg_pkg::rsp_type rsp_data
);

   // A result waiting at the output does not change.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result changed while stalled");

   // Input backpressure only comes from a full pipeline behind a stalled output.
   a_ready_cause: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid && !rsp_ready)
      else $error("input stalled without a stalled output");

   // Reset empties the pipeline.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result present right after reset");

   // A full window implies at least one finished half.
   a_avg_implies_latest: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.average_status == pcavg_pkg::ST_OK[1:0]
      |-> rsp_data.latest_status == pcavg_pkg::ST_OK[1:0])
      else $error("average ready while latest sample not ready");

   // The current is only reported once the average is valid.
   a_current_needs_avg: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.current_status == pcavg_pkg::ST_OK
      |-> rsp_data.average_status == pcavg_pkg::ST_OK[1:0])
      else $error("current reported without a valid average");

endmodule

bind ping_pong_current_average pcavg_checker u_pcavg_checker (
   .clock     (clock),
   .reset     (reset),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

// ----- tb/tb_ping_pong_current_average.sv -----
`timescale 1ns / 1ps

module tb_ping_pong_current_average;
   import pcavg_pkg::*;

   localparam int RESET_CYCLES   = 11;
   localparam int SETTLE_CYCLES  = 8;
   localparam int HOLD_CYCLES    = 300;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int PHASES         = 10;
   localparam int PHASE_ITEMS    = 200;
   localparam int HOLD_PHASE     = 2;

   typedef struct {
      req_type req;
      bit      typed;
      rsp_type want;
   } queued_item_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   req_type               req_data = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   rsp_type               rsp_data;
   logic                  csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   // Shadow of the block: run state, sums and calibration.
   bit                 run_active = 1'b0;
   bit                 fault_seen = 1'b0;
   logic [1:0]         halves_ready = 2'b00;
   int                 ring_pos = 0;
   int                 partial_sum = 0;
   int                 half_sum [2] = '{0, 0};
   int                 window_sum = 0;
   logic [11:0]        last_sample = '0;
   logic [OFS_W-1:0]   cal_offset = '0;
   logic signed [31:0] cal_gain = '0;
   bit                 cal_valid = 1'b0;

   queued_item_type send_queue [$];
   queued_item_type offered;
   rsp_type         predicted_readings [$];

   int  failures = 0;
   int  items_accepted = 0;
   int  readings_checked = 0;
   int  valid_currents = 0;
   int  burst_left = 0;
   int  gap_left = 0;
   int  pattern_left = 0;
   int  stall_mode = 0;
   int  hold_left = 0;
   bit  hold_request = 1'b0;
   int  idle_cycles = 0;

   ping_pong_current_average u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   function automatic rsp_type reading(logic [2:0] cmd_st, logic [2:0] lat_st,
                                       logic [11:0] lat_raw, logic [2:0] avg_st,
                                       logic [11:0] avg_raw, logic [2:0] cur_st,
                                       logic [31:0] cur);
      rsp_type r;
      r.cmd_status     = cmd_st[1:0];
      r.latest_status  = lat_st[1:0];
      r.latest_raw     = lat_raw;
      r.average_status = avg_st[1:0];
      r.average_raw    = avg_raw;
      r.current_status = cur_st;
      r.current_value  = cur;
      return r;
   endfunction

   function automatic logic [2:0] run_status(bit need_both);
      if (fault_seen) return ST_HW;
      if (!run_active) return ST_NOT_STARTED;
      if (need_both ? (halves_ready != BOTH_HALVES) : (halves_ready == 2'b00))
         return ST_NOT_READY;
      return ST_OK;
   endfunction

   // Advances the shadow state by one item and returns the reading it yields.
   function automatic rsp_type predict_reading(req_type r);
      logic [2:0]  cmd_st;
      logic [2:0]  lat_st;
      logic [2:0]  avg_st;
      logic [2:0]  cur_st;
      logic [11:0] avg_raw;
      logic [31:0] cur;
      logic [1:0]  merged;
      longint      avg_q5;
      longint      product;
      longint      scaled;
      int          half;
      cmd_st  = ST_OK;
      avg_raw = '0;
      cur     = '0;
      case (cmd_type'(r.cmd))
         CMD_SAMPLE: begin
            if (run_active) begin
               partial_sum += r.sample;
               if (ring_pos % HALF_LEN == HALF_LEN - 1) begin
                  half = (ring_pos >= HALF_LEN) ? 1 : 0;
                  half_sum[half] = partial_sum;
                  last_sample = r.sample;
                  merged = halves_ready | (half ? HALF1_BIT : HALF0_BIT);
                  if (merged == BOTH_HALVES) window_sum = half_sum[0] + half_sum[1];
                  halves_ready = merged;
                  partial_sum = 0;
               end
               ring_pos = (ring_pos + 1) % WIN_LEN;
            end
         end
         CMD_START: begin
            if (run_active) begin
               cmd_st = fault_seen ? ST_HW : ST_OK;
            end else begin
               halves_ready = 2'b00;
               ring_pos = 0;
               partial_sum = 0;
               half_sum[0] = 0;
               half_sum[1] = 0;
               window_sum = 0;
               last_sample = '0;
               fault_seen = 1'b0;
               run_active = 1'b1;
            end
         end
         CMD_STOP: begin
            if (!run_active) begin
               cmd_st = ST_NOT_STARTED;
            end else begin
               run_active = 1'b0;
               halves_ready = 2'b00;
            end
         end
         default: begin
            fault_seen = 1'b1;
            halves_ready = 2'b00;
         end
      endcase

      lat_st = run_status(1'b0);
      avg_st = run_status(1'b1);
      cur_st = avg_st;
      if (avg_st == ST_OK) avg_raw = 12'((window_sum + HALF_LEN) / WIN_LEN);
      if (cur_st == ST_OK && (!cal_valid || cal_gain == 0 || cal_offset > OFFSET_MAX))
         cur_st = ST_NOT_CAL;
      if (cur_st == ST_OK) begin
         avg_q5  = (longint'(window_sum) * 32 + HALF_LEN) / WIN_LEN;
         product = (avg_q5 - longint'(cal_offset)) * longint'(cal_gain);
         // Arithmetic shift floors, which gives round half up after the bias.
         scaled  = (product + 4096) >>> RND_SHIFT;
         if (scaled > 64'sd2147483647) cur = 32'h7FFF_FFFF;
         else if (scaled < -64'sd2147483648) cur = 32'h8000_0000;
         else cur = scaled[31:0];
         valid_currents++;
      end
      return reading(cmd_st, lat_st, (lat_st == ST_OK) ? last_sample : 12'h000,
                     avg_st, avg_raw, cur_st, cur);
   endfunction

   task automatic write_reg(reg_idx_type idx, logic [31:0] value);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      case (idx)
         REG_ZERO_OFFSET: cal_offset = value[OFS_W-1:0];
         REG_COUNT_GAIN:  cal_gain   = value;
         default:         cal_valid  = value[0];
      endcase
   endtask

   task automatic write_calibration(logic [16:0] ofs, logic [31:0] gain, bit cal);
      write_reg(REG_ZERO_OFFSET, 32'(ofs));
      write_reg(REG_COUNT_GAIN, gain);
      write_reg(REG_CALIBRATED, 32'(cal));
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic add_step(cmd_type cmd, logic [11:0] sample, int count, bit typed,
                           rsp_type want);
      queued_item_type item;
      item.req.cmd    = cmd;
      item.req.sample = sample;
      item.typed      = typed;
      item.want       = want;
      repeat (count) send_queue.push_back(item);
   endtask

   // Checked on the falling edge so that every update of the rising edge has landed.
   task automatic wait_until_drained();
      @(negedge clock);
      while (send_queue.size() != 0 || req_valid || predicted_readings.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         failures++;
      end
   endtask

   task automatic compare_reading(rsp_type want, rsp_type got);
      compare_field("cmd_status", 32'(want.cmd_status), 32'(got.cmd_status));
      compare_field("latest_status", 32'(want.latest_status), 32'(got.latest_status));
      compare_field("latest_raw", 32'(want.latest_raw), 32'(got.latest_raw));
      compare_field("average_status", 32'(want.average_status), 32'(got.average_status));
      compare_field("average_raw", 32'(want.average_raw), 32'(got.average_raw));
      compare_field("current_status", 32'(want.current_status), 32'(got.current_status));
      compare_field("current_value", want.current_value, got.current_value);
      readings_checked++;
   endtask

   // Sender: bursts of items with random gaps between them.
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            want = predict_reading(req_data);
            predicted_readings.push_back(offered.typed ? offered.want : want);
            items_accepted++;
         end
         if (!req_valid || req_ready) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (send_queue.size() != 0) begin
               offered = send_queue.pop_front();
               req_data  <= offered.req;
               req_valid <= 1'b1;
               if (burst_left > 1) begin
                  burst_left--;
               end else begin
                  burst_left = $urandom_range(1, 40);
                  gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Receiver: stall patterns that change every so often, plus one long hold-off.
   always @(posedge clock) begin
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else if (hold_request) begin
         hold_request = 1'b0;
         hold_left = HOLD_CYCLES;
         rsp_ready <= 1'b0;
      end else begin
         if (pattern_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            pattern_left = $urandom_range(16, 160);
         end else begin
            pattern_left--;
         end
         case (stall_mode)
            0:       rsp_ready <= 1'b1;
            1:       rsp_ready <= 1'($urandom_range(0, 1));
            2:       rsp_ready <= ($urandom_range(0, 3) == 0);
            default: rsp_ready <= (pattern_left % 3 != 0);
         endcase
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (predicted_readings.size() == 0) begin
            $error("unexpected reading: %h", rsp_data);
            failures++;
         end else begin
            compare_reading(predicted_readings.pop_front(), rsp_data);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("Timeout: no item moved for %0d cycles", WATCHDOG_LIMIT);
         $display("Test completed with failures");
         $finish;
      end
   end

   initial begin
      queued_item_type item;
      cmd_type         cmd;
      logic [16:0]     ofs;
      logic [31:0]     gain;
      bit              cal;
      bit              gen_running;
      bit              gen_fault;
      int              pick;
      int              level;
      int              v;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      write_calibration(17'd0, 32'h7FFF_FFFF, 1'b1);
      @(negedge clock);
      add_step(CMD_STOP, 12'h000, 1, 1'b1, reading(ST_NOT_STARTED, ST_NOT_STARTED, 12'h0,
               ST_NOT_STARTED, 12'h0, ST_NOT_STARTED, 32'h0));
      // A sample while stopped is dropped.
      add_step(CMD_SAMPLE, 12'hFFF, 1, 1'b1, reading(ST_OK, ST_NOT_STARTED, 12'h0,
               ST_NOT_STARTED, 12'h0, ST_NOT_STARTED, 32'h0));
      add_step(CMD_ERROR, 12'h555, 1, 1'b1, reading(ST_OK, ST_HW, 12'h0, ST_HW, 12'h0,
               ST_HW, 32'h0));
      add_step(CMD_STOP, 12'hAAA, 1, 1'b1, reading(ST_NOT_STARTED, ST_HW, 12'h0, ST_HW,
               12'h0, ST_HW, 32'h0));
      add_step(CMD_START, 12'h000, 2, 1'b1, reading(ST_OK, ST_NOT_READY, 12'h0,
               ST_NOT_READY, 12'h0, ST_NOT_READY, 32'h0));
      add_step(CMD_ERROR, 12'h000, 1, 1'b1, reading(ST_OK, ST_HW, 12'h0, ST_HW, 12'h0,
               ST_HW, 32'h0));
      // A start while running does not clear the fault.
      add_step(CMD_START, 12'h000, 1, 1'b1, reading(ST_HW, ST_HW, 12'h0, ST_HW, 12'h0,
               ST_HW, 32'h0));
      add_step(CMD_SAMPLE, 12'hFFF, 3, 1'b1, reading(ST_OK, ST_HW, 12'h0, ST_HW, 12'h0,
               ST_HW, 32'h0));
      add_step(CMD_STOP, 12'h000, 1, 1'b1, reading(ST_OK, ST_HW, 12'h0, ST_HW, 12'h0,
               ST_HW, 32'h0));
      add_step(CMD_START, 12'h000, 1, 1'b1, reading(ST_OK, ST_NOT_READY, 12'h0,
               ST_NOT_READY, 12'h0, ST_NOT_READY, 32'h0));
      add_step(CMD_SAMPLE, 12'hFFF, 15, 1'b1, reading(ST_OK, ST_NOT_READY, 12'h0,
               ST_NOT_READY, 12'h0, ST_NOT_READY, 32'h0));
      add_step(CMD_SAMPLE, 12'hFFF, 1, 1'b1, reading(ST_OK, ST_OK, 12'hFFF,
               ST_NOT_READY, 12'h0, ST_NOT_READY, 32'h0));
      add_step(CMD_SAMPLE, 12'hFFF, 15, 1'b0, '0);
      // Full-scale window with the largest gain saturates the current.
      add_step(CMD_SAMPLE, 12'hFFF, 1, 1'b1, reading(ST_OK, ST_OK, 12'hFFF, ST_OK,
               12'hFFF, ST_OK, 32'h7FFF_FFFF));
      add_step(CMD_SAMPLE, 12'h000, 16, 1'b0, '0);
      add_step(CMD_SAMPLE, 12'h555, 16, 1'b0, '0);
      add_step(CMD_SAMPLE, 12'hAAA, 16, 1'b0, '0);
      add_step(CMD_STOP, 12'h000, 1, 1'b1, reading(ST_OK, ST_NOT_STARTED, 12'h0,
               ST_NOT_STARTED, 12'h0, ST_NOT_STARTED, 32'h0));
      add_step(CMD_SAMPLE, 12'h7FF, 1, 1'b1, reading(ST_OK, ST_NOT_STARTED, 12'h0,
               ST_NOT_STARTED, 12'h0, ST_NOT_STARTED, 32'h0));
      add_step(CMD_START, 12'h000, 1, 1'b1, reading(ST_OK, ST_NOT_READY, 12'h0,
               ST_NOT_READY, 12'h0, ST_NOT_READY, 32'h0));
      wait_until_drained();

      for (int phase = 0; phase < PHASES; phase++) begin
         case (phase)
            0: begin ofs = 17'd0;      gain = 32'h0000_0000; cal = 1'b0; end
            1: begin ofs = 17'd131040; gain = 32'h8000_0000; cal = 1'b1; end
            2: begin ofs = 17'd65536;  gain = 32'h0100_0000; cal = 1'b1; end
            3: begin ofs = 17'd131041; gain = 32'h0100_0000; cal = 1'b1; end
            4: begin ofs = 17'd1024;   gain = 32'hFF00_0000; cal = 1'b0; end
            5: begin ofs = 17'd131071; gain = 32'h7FFF_FFFF; cal = 1'b1; end
            6: begin ofs = 17'd80000;  gain = 32'hFFFF_FFFF; cal = 1'b1; end
            default: begin
               ofs  = ($urandom_range(0, 5) == 0) ? 17'($urandom_range(131041, 131071))
                                                  : 17'($urandom_range(0, 131040));
               gain = $urandom;
               cal  = ($urandom_range(0, 7) != 0);
            end
         endcase
         write_calibration(ofs, gain, cal);

         @(negedge clock);
         if (phase == HOLD_PHASE) hold_request = 1'b1;
         gen_running = run_active;
         gen_fault   = fault_seen;
         level = $urandom_range(0, 4095);
         repeat (PHASE_ITEMS) begin
            pick = $urandom_range(0, 199);
            if (!gen_running) begin
               cmd = (pick < 150) ? CMD_START : (pick < 170) ? CMD_SAMPLE :
                     (pick < 190) ? CMD_STOP : CMD_ERROR;
            end else if (gen_fault) begin
               cmd = (pick < 20) ? CMD_STOP : (pick < 25) ? CMD_START : CMD_SAMPLE;
            end else begin
               cmd = (pick < 3) ? CMD_START : (pick < 6) ? CMD_STOP :
                     (pick < 7) ? CMD_ERROR : CMD_SAMPLE;
            end
            case (cmd)
               CMD_START: begin
                  if (!gen_running) gen_fault = 1'b0;
                  gen_running = 1'b1;
               end
               CMD_STOP:  gen_running = 1'b0;
               CMD_ERROR: gen_fault = 1'b1;
               default:   ;
            endcase
            case ($urandom_range(0, 7))
               0:       v = 0;
               1:       v = 4095;
               2, 3, 4: v = $urandom_range(0, 4095);
               default: begin
                  v = level + $urandom_range(0, 64) - 32;
                  if (v < 0) v = 0;
                  if (v > 4095) v = 4095;
               end
            endcase
            item.req.cmd    = cmd;
            item.req.sample = 12'(v);
            item.typed      = 1'b0;
            item.want       = '0;
            send_queue.push_back(item);
         end
         wait_until_drained();
      end

      if (predicted_readings.size() != 0) begin
         $error("%0d readings never arrived", predicted_readings.size());
         failures++;
      end
      $display("Covered %0d items and checked %0d readings over %0d calibration settings,",
               items_accepted, readings_checked, PHASES + 1);
      $display("with %0d readings carrying a calibrated current.", valid_currents);
      if (failures == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
rtl/core/pcavg_pkg.sv
rtl/core/pcavg_state.sv
rtl/core/pcavg_status.sv
rtl/core/pcavg_mult.sv
rtl/core/pcavg_out.sv
rtl/core/ping_pong_current_average.sv
rtl/core/pcavg_checker.sv
tb/tb_ping_pong_current_average.sv
